FILE: hw/rtl/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
// Used by bfa_map_ram, bfa_scan_unit and bitmap_frame_allocator_core.
`timescale 1ns / 1ps

package bfa_pkg;

  // Map geometry: one free bit per frame, stored as 64-bit map words
  localparam int NUM_FRAMES = 65536;
  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = NUM_FRAMES / WORD_BITS;
  localparam int ADDR_W     = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int FRAME_W    = 16;
  localparam int CNT_W      = 17;
  localparam int CFG_W      = 17;

  // Allocation granule of the scan window
  localparam int GRAIN_BITS = 8;

  localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(NUM_FRAMES);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RESERVE = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  // Outcome of one pass of the shared word unit
  typedef struct packed {
    logic                 hit;      // alloc: free frame in this word
    logic                 last;     // alloc: scan window ends in this word
    logic [BIT_W-1:0]     sel_bit;  // bit that was examined or taken
    logic                 was;      // old value of that bit
    logic                 cnt_up;   // free count goes up by one
    logic                 cnt_dn;   // free count goes down by one
    logic                 wr;       // word must be written back
    logic [WORD_BITS-1:0] new_word;
  } scan_res_t;

endpackage

FILE: hw/rtl/bitmap_frame_allocator_core.sv
// Top level of the bitmap frame allocator: sequencer, count and result beat.
// Depends on bfa_pkg, bfa_map_ram and bfa_scan_unit.
// Release, reserve and query read their word in READ, update it in CHECK, then give a registered result beat.
// Alloc reads one 64-frame map word per READ/CHECK pass, up to 1024 words; one
// map-RAM read port paces the scan. One item at a time.
// Reset: a clearing pass over all 1024 map words marks all frames used; busy is high meanwhile.
// The result beat is a one-cycle done strobe; the receiver cannot stall it.
`timescale 1ns / 1ps

module bitmap_frame_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [bfa_pkg::FRAME_W-1:0]   frame_number,
  // result beat
  output logic                          done,
  output logic [bfa_pkg::FRAME_W-1:0]   alloc_frame,
  output logic                          found,
  output logic                          was_free,
  output logic [bfa_pkg::CNT_W-1:0]     free_frames,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfa_pkg::CFG_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CHECK = 4'b1000
  } state_t;

  state_t                        state;
  state_t                        state_next;
  bfa_pkg::op_t                  op_q;
  logic [bfa_pkg::BIT_W-1:0]     bit_q;
  logic [bfa_pkg::ADDR_W-1:0]    word_ptr;
  logic [bfa_pkg::CNT_W-1:0]     limit;
  logic [bfa_pkg::CNT_W-1:0]     free_total;
  logic [bfa_pkg::CNT_W-1:0]     free_total_next;
  logic [bfa_pkg::CNT_W:0]       cfg_round;
  logic [bfa_pkg::CNT_W:0]       cfg_sum;
  logic                          ram_ready;
  logic [bfa_pkg::WORD_BITS-1:0] rd_data;
  bfa_pkg::scan_res_t            res;
  logic                          accept;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start & ~busy;

  // Scan limit: round up to the grain, cap at the map size
  assign cfg_sum   = {1'b0, cfg_data} + (bfa_pkg::CNT_W + 1)'(bfa_pkg::GRAIN_BITS - 1);
  assign cfg_round = cfg_sum & ~((bfa_pkg::CNT_W + 1)'(bfa_pkg::GRAIN_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= bfa_pkg::LIMIT_MAX;
    end else if (cfg_valid & cfg_ready) begin
      if (cfg_round > {1'b0, bfa_pkg::LIMIT_MAX}) begin
        limit <= bfa_pkg::LIMIT_MAX;
      end else begin
        limit <= cfg_round[bfa_pkg::CNT_W-1:0];
      end
    end
  end

  bfa_map_ram u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (state == ST_READ),
    .rd_addr (word_ptr),
    .rd_data (rd_data),
    .wr_en   ((state == ST_CHECK) & res.wr),
    .wr_addr (word_ptr),
    .wr_data (res.new_word),
    .ready   (ram_ready)
  );

  bfa_scan_unit u_scan (
    .op       (op_q),
    .word     (rd_data),
    .word_idx (word_ptr),
    .limit    (limit),
    .bit_sel  (bit_q),
    .res      (res)
  );

  // Count after this word's update
  always_comb begin
    free_total_next = free_total;
    if (res.cnt_up) begin
      free_total_next = free_total + 1'b1;
    end else if (res.cnt_dn) begin
      free_total_next = free_total - 1'b1;
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (ram_ready) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && !((bfa_pkg::op_t'(opcode) == bfa_pkg::OP_ALLOC) && (limit == '0))) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if ((op_q == bfa_pkg::OP_ALLOC) && !res.hit && !res.last) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Command capture and scan pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= bfa_pkg::op_t'(opcode);
      bit_q <= frame_number[bfa_pkg::BIT_W-1:0];
      if (bfa_pkg::op_t'(opcode) == bfa_pkg::OP_ALLOC) begin
        word_ptr <= '0;
      end else begin
        word_ptr <= frame_number[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
      end
    end else if ((state == ST_CHECK) && (state_next == ST_READ)) begin
      word_ptr <= word_ptr + 1'b1;
    end
  end

  // Free-frame count
  always_ff @(posedge clk) begin
    if (rst) begin
      free_total <= '0;
    end else if (state == ST_CHECK) begin
      free_total <= free_total_next;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == ST_CHECK) && (state_next == ST_IDLE)) ||
              (accept && (state_next == ST_IDLE));
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      free_frames <= free_total_next;
      was_free    <= res.was;
      if (op_q == bfa_pkg::OP_ALLOC) begin
        found <= res.hit;
        if (res.hit) begin
          alloc_frame <= {word_ptr, res.sel_bit};
        end else begin
          alloc_frame <= '0;
        end
      end else begin
        found       <= 1'b1;
        alloc_frame <= '0;
      end
    end else if (accept) begin
      // empty scan window: alloc answers at once
      free_frames <= free_total;
      was_free    <= 1'b0;
      found       <= 1'b0;
      alloc_frame <= '0;
    end
  end

endmodule

FILE: hw/rtl/bfa_map_ram.sv
// Free-map storage: MAP_WORDS x WORD_BITS, one read and one write port.
// Runs a clearing pass after reset. Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_map_ram (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [bfa_pkg::ADDR_W-1:0]    rd_addr,
  output logic [bfa_pkg::WORD_BITS-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [bfa_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [bfa_pkg::WORD_BITS-1:0] wr_data,
  output logic                          ready
);

  logic [bfa_pkg::WORD_BITS-1:0] mem [bfa_pkg::MAP_WORDS];
  logic [bfa_pkg::ADDR_W-1:0]    clr_addr;
  logic                          clearing;

  // Clearing sweep: every word to zero (all frames used)
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == bfa_pkg::ADDR_W'(bfa_pkg::MAP_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write port, shared with the sweep
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = ~clearing;

endmodule

FILE: hw/rtl/bfa_scan_unit.sv
// Shared map-word unit: window mask, lowest-free search and bit update.
// Pure logic, reused once per word read. Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_scan_unit (
  input  bfa_pkg::op_t                  op,
  input  logic [bfa_pkg::WORD_BITS-1:0] word,
  input  logic [bfa_pkg::ADDR_W-1:0]    word_idx,
  input  logic [bfa_pkg::CNT_W-1:0]     limit,
  input  logic [bfa_pkg::BIT_W-1:0]     bit_sel,
  output bfa_pkg::scan_res_t            res
);

  localparam int HI_W = bfa_pkg::CNT_W - bfa_pkg::BIT_W;

  logic [bfa_pkg::WORD_BITS-1:0] win_mask;
  logic [bfa_pkg::WORD_BITS-1:0] cand;
  logic [bfa_pkg::WORD_BITS-1:0] iso;
  logic [bfa_pkg::BIT_W-1:0]     low_idx;
  logic [bfa_pkg::CNT_W-1:0]     word_end;
  logic                          full_word;
  logic                          part_word;
  logic                          bit_old;

  assign full_word = limit[bfa_pkg::CNT_W-1:bfa_pkg::BIT_W] > HI_W'(word_idx);
  assign part_word = limit[bfa_pkg::CNT_W-1:bfa_pkg::BIT_W] == HI_W'(word_idx);
  assign word_end  = {HI_W'(word_idx) + HI_W'(1), bfa_pkg::BIT_W'(0)};

  // Bits of this word that lie below the scan limit
  always_comb begin
    for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
      win_mask[i] = full_word |
                    (part_word & (bfa_pkg::BIT_W'(i) < limit[bfa_pkg::BIT_W-1:0]));
    end
  end

  // Lowest free bit: isolate, then encode the one-hot
  assign cand = word & win_mask;
  assign iso  = cand & (~cand + 1'b1);

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
      if (iso[i]) begin
        low_idx = low_idx | bfa_pkg::BIT_W'(i);
      end
    end
  end

  assign bit_old = word[bit_sel];

  // Result per opcode
  always_comb begin
    res          = '0;
    res.new_word = word;
    case (op)
      bfa_pkg::OP_ALLOC: begin
        res.hit     = |cand;
        res.last    = word_end >= limit;
        res.sel_bit = low_idx;
        res.was     = |cand;
        res.cnt_dn  = |cand;
        res.wr      = |cand;
        res.new_word = word & ~iso;
      end
      bfa_pkg::OP_RELEASE: begin
        res.sel_bit = bit_sel;
        res.was     = bit_old;
        res.cnt_up  = ~bit_old;
        res.wr      = ~bit_old;
        res.new_word[bit_sel] = 1'b1;
      end
      bfa_pkg::OP_RESERVE: begin
        res.sel_bit = bit_sel;
        res.was     = bit_old;
        res.cnt_dn  = bit_old;
        res.wr      = bit_old;
        res.new_word[bit_sel] = 1'b0;
      end
      bfa_pkg::OP_QUERY: begin
        res.sel_bit = bit_sel;
        res.was     = bit_old;
      end
      default: begin
        res.sel_bit = bit_sel;
      end
    endcase
  end

endmodule

FILE: verif/bitmap_frame_allocator_core_tb.sv
// Self-checking testbench for bitmap_frame_allocator_core: first-fit frame allocator.
// Depends on bfa_pkg and the allocator RTL. It predicts each result beat from its own
// model of the free map, then compares the beats field by field.
`timescale 1ns / 1ps

module bitmap_frame_allocator_core_tb;

  typedef enum logic [1:0] {BEAT_CMD, BEAT_CFG, BEAT_DRAIN} beat_kind_t;

  typedef struct {
    beat_kind_t                  kind;
    bfa_pkg::op_t                op;
    logic [bfa_pkg::FRAME_W-1:0] frame;
    logic [bfa_pkg::CFG_W-1:0]   cfg;
  } stim_beat_t;

  typedef struct {
    logic [bfa_pkg::FRAME_W-1:0] frame;
    logic                        found;
    logic                        was;
    logic [bfa_pkg::CNT_W-1:0]   count;
  } alloc_reply_t;

  // DUT inputs, all driven to known values from time zero
  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  opcode = bfa_pkg::OP_QUERY;
  logic [bfa_pkg::FRAME_W-1:0] frame_number = '0;
  logic                        done;
  logic [bfa_pkg::FRAME_W-1:0] alloc_frame;
  logic                        found;
  logic                        was_free;
  logic [bfa_pkg::CNT_W-1:0]   free_frames;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [bfa_pkg::CFG_W-1:0]   cfg_data = '0;

  // Stimulus beats and outstanding predicted replies
  stim_beat_t   stim_beats[$];
  alloc_reply_t replies[$];
  int           mismatches = 0;
  int           cmds_sent = 0;
  logic         cmd_taken = 1'b0;
  logic         cfg_taken = 1'b0;

  // Predictor state: free bit per frame, free count, scan window register
  bit           pred_free [bfa_pkg::NUM_FRAMES];
  int unsigned  free_count = 0;
  int unsigned  window_cfg = bfa_pkg::NUM_FRAMES;

  bitmap_frame_allocator_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .frame_number (frame_number),
    .done         (done),
    .alloc_frame  (alloc_frame),
    .found        (found),
    .was_free     (was_free),
    .free_frames  (free_frames),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // Apply one request to the predicted map and return the reply it gives
  function automatic alloc_reply_t apply_request(bfa_pkg::op_t op,
                                                 logic [bfa_pkg::FRAME_W-1:0] fn);
    alloc_reply_t r;
    int unsigned  lim;
    r.frame = '0;
    r.found = 1'b1;
    r.was   = 1'b0;
    if (op == bfa_pkg::OP_ALLOC) begin
      // window rounds up to the grain and is capped at the map size
      lim = ((window_cfg + bfa_pkg::GRAIN_BITS - 1) / bfa_pkg::GRAIN_BITS) *
            bfa_pkg::GRAIN_BITS;
      if (lim > bfa_pkg::NUM_FRAMES) lim = bfa_pkg::NUM_FRAMES;
      r.found = 1'b0;
      for (int unsigned f = 0; f < lim && !r.found; f++) begin
        if (pred_free[f]) begin
          pred_free[f] = 1'b0;
          free_count--;
          r.frame = f[bfa_pkg::FRAME_W-1:0];
          r.found = 1'b1;
          r.was   = 1'b1;
        end
      end
    end else begin
      r.was = pred_free[fn];
      if (op == bfa_pkg::OP_RELEASE && !pred_free[fn]) begin
        pred_free[fn] = 1'b1;
        free_count++;
      end else if (op == bfa_pkg::OP_RESERVE && pred_free[fn]) begin
        pred_free[fn] = 1'b0;
        free_count--;
      end
    end
    r.count = free_count[bfa_pkg::CNT_W-1:0];
    return r;
  endfunction

  task automatic add_cmd(bfa_pkg::op_t op, logic [bfa_pkg::FRAME_W-1:0] fn);
    stim_beat_t b;
    b.kind  = BEAT_CMD;
    b.op    = op;
    b.frame = fn;
    b.cfg   = '0;
    stim_beats.push_back(b);
  endtask

  task automatic add_cfg(logic [bfa_pkg::CFG_W-1:0] val);
    stim_beat_t b;
    b.kind  = BEAT_CFG;
    b.op    = bfa_pkg::OP_QUERY;
    b.frame = '0;
    b.cfg   = val;
    stim_beats.push_back(b);
  endtask

  task automatic add_drain();
    stim_beat_t b;
    b.kind  = BEAT_DRAIN;
    b.op    = bfa_pkg::OP_QUERY;
    b.frame = '0;
    b.cfg   = '0;
    stim_beats.push_back(b);
  endtask

  // Driver: launches beats at the falling edge, holds start until accepted
  always @(negedge clk) begin : drv
    logic       n_start;
    logic       n_cfgv;
    logic       drained;
    stim_beat_t head;
    if (!rst) begin
      n_start = start && !cmd_taken;
      n_cfgv  = cfg_valid && !cfg_taken;
      drained = replies.size() == 0 && !busy && !done;
      if (!n_start && !n_cfgv && stim_beats.size() > 0) begin
        head = stim_beats[0];
        case (head.kind)
          BEAT_CMD: begin
            // random gaps, except for a long burst in the middle of the run
            if ((cmds_sent >= 600 && cmds_sent < 850) || $urandom_range(99) >= 7) begin
              void'(stim_beats.pop_front());
              n_start = 1'b1;
              opcode <= head.op;
              frame_number <= head.frame;
              cmds_sent++;
            end
          end
          BEAT_CFG: begin
            if (drained) begin
              void'(stim_beats.pop_front());
              n_cfgv = 1'b1;
              cfg_data <= head.cfg;
            end
          end
          default: begin
            if (drained) void'(stim_beats.pop_front());
          end
        endcase
      end
      start <= n_start;
      cfg_valid <= n_cfgv;
    end
  end

  // Monitor: predicts on accepted commands, checks every done beat
  always @(posedge clk) begin : mon
    alloc_reply_t want;
    cmd_taken <= start && !busy;
    cfg_taken <= cfg_valid && cfg_ready;
    if (!rst) begin
      if (done) begin
        if (replies.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          want = replies.pop_front();
          if (alloc_frame !== want.frame) begin
            $error("alloc_frame: expected %0d, got %0d", want.frame, alloc_frame);
            mismatches++;
          end
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            mismatches++;
          end
          if (was_free !== want.was) begin
            $error("was_free: expected %0d, got %0d", want.was, was_free);
            mismatches++;
          end
          if (free_frames !== want.count) begin
            $error("free_frames: expected %0d, got %0d", want.count, free_frames);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        replies.push_back(apply_request(bfa_pkg::op_t'(opcode), frame_number));
      end
      if (cfg_valid && cfg_ready) window_cfg = cfg_data;
    end
  end

  // Stimulus, reset and end of run
  initial begin : seq
    int unsigned  cfgv;
    int unsigned  wv;
    int unsigned  hot;
    int unsigned  lo;
    int unsigned  r;
    int unsigned  fv;
    bfa_pkg::op_t op;

    // directed: empty map, extremes of frame number, no-flip cases, frame zero
    add_cfg(17'd65536);
    add_cmd(bfa_pkg::OP_ALLOC, 16'hFFFF);
    add_cmd(bfa_pkg::OP_QUERY, 16'h0000);
    add_cmd(bfa_pkg::OP_RELEASE, 16'h0000);
    add_cmd(bfa_pkg::OP_RELEASE, 16'hFFFF);
    add_cmd(bfa_pkg::OP_RELEASE, 16'h5555);
    add_cmd(bfa_pkg::OP_RELEASE, 16'hAAAA);
    add_cmd(bfa_pkg::OP_RELEASE, 16'h0000);
    add_cmd(bfa_pkg::OP_QUERY, 16'hFFFF);
    add_cmd(bfa_pkg::OP_ALLOC, 16'h1234);
    add_cmd(bfa_pkg::OP_ALLOC, 16'h0000);
    add_cmd(bfa_pkg::OP_RESERVE, 16'hAAAA);
    add_cmd(bfa_pkg::OP_RESERVE, 16'hAAAA);
    add_cmd(bfa_pkg::OP_ALLOC, 16'h0000);
    add_cmd(bfa_pkg::OP_ALLOC, 16'h0000);
    // zero window: nothing can be found
    add_cfg(17'd0);
    add_cmd(bfa_pkg::OP_RELEASE, 16'd3);
    add_cmd(bfa_pkg::OP_ALLOC, 16'd0);
    // window not on the grain rounds up to 16
    add_cfg(17'd13);
    add_cmd(bfa_pkg::OP_RELEASE, 16'd15);
    add_cmd(bfa_pkg::OP_ALLOC, 16'd0);
    add_cmd(bfa_pkg::OP_ALLOC, 16'd0);
    add_cmd(bfa_pkg::OP_RELEASE, 16'd16);
    add_cmd(bfa_pkg::OP_ALLOC, 16'd0);
    // window above the map is capped
    add_cfg(17'h1FFFF);
    add_cmd(bfa_pkg::OP_ALLOC, 16'd0);
    add_cmd(bfa_pkg::OP_QUERY, 16'd16);

    // random phases, each under its own window setting
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: cfgv = 8;
        1: cfgv = 65536;
        2: cfgv = 131071;
        3: cfgv = 0;
        default: cfgv = (p % 2 == 0) ? $urandom_range(1, 128) * 8 : $urandom_range(0, 131071);
      endcase
      add_cfg(cfgv[bfa_pkg::CFG_W-1:0]);
      wv  = ((cfgv + 7) / 8) * 8;
      if (wv > bfa_pkg::NUM_FRAMES) wv = bfa_pkg::NUM_FRAMES;
      hot = (wv == 0) ? 64 : ((wv > 512) ? 512 : wv);
      lo  = (wv > 8) ? wv - 8 : 0;
      for (int i = 0; i < 153; i++) begin
        if (p == 4 && i == 76) add_drain();
        r = $urandom_range(99);
        if (r < 35) op = bfa_pkg::OP_ALLOC;
        else if (r < 65) op = bfa_pkg::OP_RELEASE;
        else if (r < 80) op = bfa_pkg::OP_RESERVE;
        else op = bfa_pkg::OP_QUERY;
        // mostly frames the scan reaches fast, some at the window edge, some anywhere
        r = $urandom_range(99);
        if (r < 60) fv = $urandom_range(0, hot + 7);
        else if (r < 75) fv = lo + $urandom_range(0, 15);
        else fv = $urandom_range(0, 65535);
        if (fv > 65535) fv = 65535;
        add_cmd(op, fv[bfa_pkg::FRAME_W-1:0]);
      end
    end

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    while (stim_beats.size() != 0 || start || cfg_valid || replies.size() != 0)
      @(posedge clk);
    repeat (2100) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_map_ram.sv
hw/rtl/bfa_scan_unit.sv
hw/rtl/bitmap_frame_allocator_core.sv
verif/bitmap_frame_allocator_core_tb.sv
